FILE: rtl/lcp_pkg.sv
`default_nettype none

package lcp_pkg;

  // Pipeline stage numbers, counted from the input register (stage 1)
  localparam int S_PAR  = 4;    // parallel flag settled
  localparam int S_UNIT = 68;   // unit vectors out of the normalizers
  localparam int S_DEN  = 72;   // numerators and clamped denominator
  localparam int S_DIV  = 73;   // divider operands
  localparam int S_SAT  = 74;   // t clamp flags
  localparam int T_BITS = 34;   // quotient bits of the t divider
  localparam int S_QUO  = S_DIV + T_BITS;
  localparam int S_T    = S_QUO + 1;
  localparam int S_TP   = S_T + 1;
  localparam int S_OUT  = S_TP + 1;

  localparam logic [33:0] T_LIMIT = 34'h3_FFFF_FFFF;
  localparam logic [34:0] ONE_Q30 = 35'h0_4000_0000;

  typedef logic signed [31:0] q16_t;

  // magnitude of a 32-bit signed value, -2^31 maps to 2^31
  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    return a[31] ? 32'(-a) : 32'(a);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lcp_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Requires rem_i < div_i; quo_o gives the quotient of {rem_i, low_i} / div_i from the last stage register.
module lcp_div #(
  parameter int RW = 32,
  parameter int QW = 31
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [RW-1:0] rem_i,
  input  wire logic [QW-1:0] low_i,
  input  wire logic [RW-1:0] div_i,
  output logic      [QW-1:0] quo_o
);

  logic [RW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [RW-1:0] div_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [RW-1:0] rem_nxt [QW];
  logic [QW-1:0] low_nxt [QW];
  logic [RW-1:0] div_nxt [QW];
  logic [QW-1:0] quo_nxt [QW];

  // one trial subtraction per stage
  always_comb begin
    logic [RW-1:0] rp;
    logic [QW-1:0] lp;
    logic [RW-1:0] dp;
    logic [QW-1:0] qp;
    logic [RW:0]   sh;
    logic          qb;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rp = rem_i;
        lp = low_i;
        dp = div_i;
        qp = '0;
      end else begin
        rp = rem_r[k-1];
        lp = low_r[k-1];
        dp = div_r[k-1];
        qp = quo_r[k-1];
      end
      sh = {rp, lp[QW-1]};
      qb = (sh >= {1'b0, dp});
      if (qb) begin
        rem_nxt[k] = RW'(sh - {1'b0, dp});
      end else begin
        rem_nxt[k] = sh[RW-1:0];
      end
      low_nxt[k] = {lp[QW-2:0], 1'b0};
      div_nxt[k] = dp;
      quo_nxt[k] = {qp[QW-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        div_r[k] <= div_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quo_o = quo_r[QW-1];

endmodule

`default_nettype wire

FILE: rtl/lcp_unit.sv
`default_nettype none

// Direction normalizer: Q16.16 vector in, Q2.30 unit vector out.
// Stages: magnitude, common left shift, squares, sum, 32 root stages,
// 31 divider stages, sign and output register.
module lcp_unit (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] dir_i [3],
  output logic signed      [31:0] u_o [3]
);

  localparam int SQ_FIRST = 5;
  localparam int SQ_LAST  = SQ_FIRST + 31;
  localparam int DV_LAST  = SQ_LAST + 31;

  logic [31:0]        ea_r [3];
  logic [31:0]        e_r [2:SQ_LAST][3];
  logic               neg_r [1:DV_LAST][3];
  logic               zero_r [2:DV_LAST];
  logic [63:0]        sq_r [3];
  logic [63:0]        len_r;
  logic [33:0]        srem_r [SQ_FIRST:SQ_LAST];
  logic [31:0]        sroot_r [SQ_FIRST:SQ_LAST];
  logic [63:0]        sx_r [SQ_FIRST:SQ_LAST];
  logic [33:0]        srem_nxt [SQ_FIRST:SQ_LAST];
  logic [31:0]        sroot_nxt [SQ_FIRST:SQ_LAST];
  logic [63:0]        sx_nxt [SQ_FIRST:SQ_LAST];
  logic [4:0]         shift_nxt;
  logic [31:0]        ormag;
  logic [30:0]        quo [3];
  logic signed [31:0] u_r [3];

  // shift that brings the largest component to at least 2^30
  always_comb begin
    ormag = ea_r[0] | ea_r[1] | ea_r[2];
    shift_nxt = '0;
    for (int i = 0; i < 30; i++) begin
      if (ormag[i]) shift_nxt = 5'(30 - i);
    end
    if (ormag[31:30] != 2'b00) shift_nxt = '0;
  end

  // integer square root, two radicand bits per stage
  always_comb begin
    logic [33:0] rp;
    logic [31:0] qp;
    logic [63:0] xp;
    logic [35:0] tr;
    logic [35:0] tt;
    for (int j = SQ_FIRST; j <= SQ_LAST; j++) begin
      if (j == SQ_FIRST) begin
        rp = '0;
        qp = '0;
        xp = len_r;
      end else begin
        rp = srem_r[j-1];
        qp = sroot_r[j-1];
        xp = sx_r[j-1];
      end
      tr = {rp, xp[63:62]};
      tt = {2'b00, qp, 2'b01};
      if (tr >= tt) begin
        srem_nxt[j]  = 34'(tr - tt);
        sroot_nxt[j] = {qp[30:0], 1'b1};
      end else begin
        srem_nxt[j]  = tr[33:0];
        sroot_nxt[j] = {qp[30:0], 1'b0};
      end
      sx_nxt[j] = {xp[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitude and sign
      for (int i = 0; i < 3; i++) begin
        ea_r[i]     <= lcp_pkg::mag32(dir_i[i]);
        neg_r[1][i] <= dir_i[i][31];
      end
      // normalize
      for (int i = 0; i < 3; i++) e_r[2][i] <= ea_r[i] << shift_nxt;
      zero_r[2] <= (ormag == 32'd0);
      // squares, then length squared
      for (int i = 0; i < 3; i++) sq_r[i] <= 64'(e_r[2][i]) * 64'(e_r[2][i]);
      len_r <= sq_r[0] + sq_r[1] + sq_r[2];
      for (int j = SQ_FIRST; j <= SQ_LAST; j++) begin
        srem_r[j]  <= srem_nxt[j];
        sroot_r[j] <= sroot_nxt[j];
        sx_r[j]    <= sx_nxt[j];
      end
      // sideband delay lines
      for (int k = 3; k <= SQ_LAST; k++) e_r[k] <= e_r[k-1];
      for (int k = 2; k <= DV_LAST; k++) neg_r[k] <= neg_r[k-1];
      for (int k = 3; k <= DV_LAST; k++) zero_r[k] <= zero_r[k-1];
      // apply sign, zero vector stays zero
      for (int i = 0; i < 3; i++) begin
        if (zero_r[DV_LAST]) begin
          u_r[i] <= '0;
        end else if (neg_r[DV_LAST][i]) begin
          u_r[i] <= -$signed({1'b0, quo[i]});
        end else begin
          u_r[i] <= $signed({1'b0, quo[i]});
        end
      end
    end
  end

  // component * 2^30 / length
  for (genvar i = 0; i < 3; i++) begin : g_div
    lcp_div #(.RW(32), .QW(31)) u_div (
      .clk   (clk),
      .en    (en),
      .rem_i ({1'b0, e_r[SQ_LAST][i][31:1]}),
      .low_i ({e_r[SQ_LAST][i][0], 30'd0}),
      .div_i (sroot_r[SQ_LAST]),
      .quo_o (quo[i])
    );
  end

  assign u_o = u_r;

endmodule

`default_nettype wire

FILE: rtl/line_line_closest_points_top.sv
// Closest points between two 3D lines.
// Input channel (in_valid / in_stall): one request carries both lines, each as
// a base point and a direction in signed Q16.16. Output channel (out_valid /
// out_stall): the closest point on each line, saturated to Q16.16, and
// out_lines_parallel, set when the squared cross product of the raw
// directions is below the epsilon register; then the base points come back.
// Configuration: cfg_valid / cfg_ready writes cfg_parallel_epsilon; ready is
// always high. Write it only while no request is in flight.
// Throughput: one request per cycle while out_stall does not hold the pipeline.
// The pipeline includes the 32-stage square root and 31-stage divider of the
// normalizers plus the 34-stage t divider, all fully pipelined.
// When out_stall is high while a result is presented, the whole pipeline
// holds and in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and sets epsilon to 1.
`default_nettype none

module line_line_closest_points_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_first_point_x,
  input  wire logic signed [31:0] in_first_point_y,
  input  wire logic signed [31:0] in_first_point_z,
  input  wire logic signed [31:0] in_first_dir_x,
  input  wire logic signed [31:0] in_first_dir_y,
  input  wire logic signed [31:0] in_first_dir_z,
  input  wire logic signed [31:0] in_second_point_x,
  input  wire logic signed [31:0] in_second_point_y,
  input  wire logic signed [31:0] in_second_point_z,
  input  wire logic signed [31:0] in_second_dir_x,
  input  wire logic signed [31:0] in_second_dir_y,
  input  wire logic signed [31:0] in_second_dir_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [31:0] out_near_first_x,
  output logic signed      [31:0] out_near_first_y,
  output logic signed      [31:0] out_near_first_z,
  output logic signed      [31:0] out_near_second_x,
  output logic signed      [31:0] out_near_second_y,
  output logic signed      [31:0] out_near_second_z,
  output logic                    out_lines_parallel,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [31:0] cfg_parallel_epsilon
);

  localparam int S_PAR  = lcp_pkg::S_PAR;
  localparam int S_UNIT = lcp_pkg::S_UNIT;
  localparam int S_DEN  = lcp_pkg::S_DEN;
  localparam int S_DIV  = lcp_pkg::S_DIV;
  localparam int S_SAT  = lcp_pkg::S_SAT;
  localparam int S_QUO  = lcp_pkg::S_QUO;
  localparam int S_T    = lcp_pkg::S_T;
  localparam int S_TP   = lcp_pkg::S_TP;
  localparam int S_OUT  = lcp_pkg::S_OUT;

  // truncated product, Q16.16 x Q16.16
  function automatic logic signed [47:0] tp16(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic [63:0]        p;
    logic signed [47:0] m;
    p = 64'(lcp_pkg::mag32(a)) * 64'(lcp_pkg::mag32(b));
    m = $signed({1'b0, p[62:16]});
    return (a[31] ^ b[31]) ? -m : m;
  endfunction

  // difference vector times unit component, Q16.16
  function automatic logic signed [33:0] tp_du(input logic signed [32:0] d,
                                                input logic signed [31:0] u);
    logic [32:0]        dm;
    logic [64:0]        p;
    logic signed [33:0] m;
    dm = d[32] ? 33'(-d) : 33'(d);
    p  = 65'(dm) * 65'(lcp_pkg::mag32(u));
    m  = $signed({1'b0, p[62:30]});
    return (d[32] ^ u[31]) ? -m : m;
  endfunction

  // unit times unit, Q2.30
  function automatic logic signed [31:0] tp_uu(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic [63:0]        p;
    logic signed [31:0] m;
    p = 64'(lcp_pkg::mag32(a)) * 64'(lcp_pkg::mag32(b));
    m = $signed({1'b0, p[60:30]});
    return (a[31] ^ b[31]) ? -m : m;
  endfunction

  // dot product times dv, Q16.16
  function automatic logic signed [37:0] tp_dv(input logic signed [35:0] d,
                                                input logic signed [32:0] v);
    logic [35:0]        dm;
    logic [32:0]        vm;
    logic [68:0]        p;
    logic signed [37:0] m;
    dm = d[35] ? 36'(-d) : 36'(d);
    vm = v[32] ? 33'(-v) : 33'(v);
    p  = 69'(dm) * 69'(vm);
    m  = $signed({1'b0, p[66:30]});
    return (d[35] ^ v[32]) ? -m : m;
  endfunction

  // clamp to the Q16.16 range
  function automatic logic signed [31:0] sat32(input logic signed [36:0] x);
    if (!x[36] && (x[35:31] != 5'h00)) return 32'sh7FFF_FFFF;
    if (x[36] && (x[35:31] != 5'h1F)) return $signed(32'h8000_0000);
    return x[31:0];
  endfunction

  logic               adv;
  logic [S_OUT:1]     v_r;
  logic [31:0]        eps_r;

  logic signed [31:0] pt1_w [3];
  logic signed [31:0] pt2_w [3];
  logic signed [31:0] d1_w [3];
  logic signed [31:0] d2_w [3];

  logic signed [31:0] p1_r [1:S_TP][3];
  logic signed [31:0] p2_r [1:S_TP][3];
  logic signed [32:0] diff_r [1:S_UNIT][3];
  logic               par_r [S_PAR:S_TP];

  logic signed [47:0] cpa_r [3];
  logic signed [47:0] cpb_r [3];
  logic [23:0]        cm_r [3];
  logic [23:0]        cm_nxt [3];
  logic               big2_r, big2_nxt, big3_r;
  logic [31:0]        csq_r [3];
  logic [33:0]        csum;

  logic signed [31:0] u1 [3];
  logic signed [31:0] u2 [3];
  logic signed [31:0] u1d_r [S_UNIT+1:S_T][3];
  logic signed [31:0] u2d_r [S_UNIT+1:S_T][3];

  logic signed [33:0] pd1_r [3];
  logic signed [33:0] pd2_r [3];
  logic signed [31:0] pv_r [3];
  logic signed [35:0] dd1_r, dd2_r, dd1b_r, dd2b_r;
  logic signed [32:0] dv_r;
  logic [33:0]        vv_r;
  logic [63:0]        vv_p;
  logic [32:0]        dv_m;
  logic signed [37:0] td2v_r, td1v_r;
  logic signed [38:0] num_r [2];
  logic signed [34:0] den_s;
  logic [30:0]        den_r, den73_r;
  logic [38:0]        a_r [2];
  logic               sgn_r [S_DIV:S_QUO][2];
  logic               sat_r [S_SAT:S_QUO][2];
  logic [33:0]        quo [2];
  logic [33:0]        tm_r [2];
  logic               tn_r [2];
  logic signed [35:0] tp1_r [3];
  logic signed [35:0] tp2_r [3];
  logic signed [31:0] on1_r [3];
  logic signed [31:0] on2_r [3];
  logic               opar_r;

  assign pt1_w = '{in_first_point_x, in_first_point_y, in_first_point_z};
  assign pt2_w = '{in_second_point_x, in_second_point_y, in_second_point_z};
  assign d1_w  = '{in_first_dir_x, in_first_dir_y, in_first_dir_z};
  assign d2_w  = '{in_second_dir_x, in_second_dir_y, in_second_dir_z};

  // whole pipeline holds while the result register is stalled
  assign adv       = !(v_r[S_OUT] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = v_r[S_OUT];
  assign cfg_ready = 1'b1;

  // control: valid bits and epsilon register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      eps_r <= 32'd1;
    end else begin
      if (adv) v_r <= {v_r[S_OUT-1:1], in_valid};
      if (cfg_valid && cfg_ready) eps_r <= cfg_parallel_epsilon;
    end
  end

  // cross product component and its magnitude
  always_comb begin
    logic signed [48:0] cdif;
    logic [48:0]        cmag;
    big2_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      cdif = 49'(cpa_r[i]) - 49'(cpb_r[i]);
      cmag = cdif[48] ? 49'(-cdif) : 49'(cdif);
      cm_nxt[i] = cmag[23:0];
      if (cmag[48:24] != 25'd0) big2_nxt = 1'b1;
    end
  end

  assign csum = 34'(csq_r[0]) + 34'(csq_r[1]) + 34'(csq_r[2]);

  // parallel test path, base points and their delay lines
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[1][i]   <= pt1_w[i];
        p2_r[1][i]   <= pt2_w[i];
        diff_r[1][i] <= 33'(pt2_w[i]) - 33'(pt1_w[i]);
      end
      cpa_r[0] <= tp16(d1_w[1], d2_w[2]);
      cpb_r[0] <= tp16(d1_w[2], d2_w[1]);
      cpa_r[1] <= tp16(d1_w[2], d2_w[0]);
      cpb_r[1] <= tp16(d1_w[0], d2_w[2]);
      cpa_r[2] <= tp16(d1_w[0], d2_w[1]);
      cpb_r[2] <= tp16(d1_w[1], d2_w[0]);
      cm_r   <= cm_nxt;
      big2_r <= big2_nxt;
      for (int i = 0; i < 3; i++) csq_r[i] <= 32'((48'(cm_r[i]) * 48'(cm_r[i])) >> 16);
      big3_r <= big2_r;
      par_r[S_PAR] <= !big3_r && (csum < 34'(eps_r));
      for (int k = 2; k <= S_TP; k++) begin
        p1_r[k] <= p1_r[k-1];
        p2_r[k] <= p2_r[k-1];
      end
      for (int k = 2; k <= S_UNIT; k++) diff_r[k] <= diff_r[k-1];
      for (int k = S_PAR + 1; k <= S_TP; k++) par_r[k] <= par_r[k-1];
    end
  end

  // unit direction vectors
  lcp_unit u_unit1 (.clk(clk), .en(adv), .dir_i(d1_w), .u_o(u1));
  lcp_unit u_unit2 (.clk(clk), .en(adv), .dir_i(d2_w), .u_o(u2));

  assign dv_m = dv_r[32] ? 33'(-dv_r) : 33'(dv_r);
  assign vv_p = 64'(dv_m) * 64'(dv_m);
  assign den_s = $signed(lcp_pkg::ONE_Q30) - $signed({1'b0, vv_r});

  // dot products, numerators, denominator
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pd1_r[i] <= tp_du(diff_r[S_UNIT][i], u1[i]);
        pd2_r[i] <= tp_du(diff_r[S_UNIT][i], u2[i]);
        pv_r[i]  <= tp_uu(u1[i], u2[i]);
      end
      dd1_r <= 36'(pd1_r[0]) + 36'(pd1_r[1]) + 36'(pd1_r[2]);
      dd2_r <= 36'(pd2_r[0]) + 36'(pd2_r[1]) + 36'(pd2_r[2]);
      dv_r  <= 33'(pv_r[0]) + 33'(pv_r[1]) + 33'(pv_r[2]);
      vv_r   <= vv_p[63:30];
      td2v_r <= tp_dv(dd2_r, dv_r);
      td1v_r <= tp_dv(dd1_r, dv_r);
      dd1b_r <= dd1_r;
      dd2b_r <= dd2_r;
      num_r[0] <= 39'(dd1b_r) - 39'(td2v_r);
      num_r[1] <= 39'(td1v_r) - 39'(dd2b_r);
      den_r    <= (den_s < 35'sd1) ? 31'd1 : den_s[30:0];
      for (int j = 0; j < 2; j++) begin
        a_r[j]        <= num_r[j][38] ? 39'(-num_r[j]) : 39'(num_r[j]);
        sgn_r[S_DIV][j] <= num_r[j][38];
        sat_r[S_SAT][j] <= (a_r[j][38:34] != 5'd0) ||
                           ({1'b0, a_r[j][33:4]} >= den73_r);
      end
      den73_r <= den_r;
      for (int k = S_DIV + 1; k <= S_QUO; k++) sgn_r[k] <= sgn_r[k-1];
      for (int k = S_SAT + 1; k <= S_QUO; k++) sat_r[k] <= sat_r[k-1];
    end
  end

  // t = num * 2^30 / den
  for (genvar j = 0; j < 2; j++) begin : g_tdiv
    lcp_div #(.RW(31), .QW(lcp_pkg::T_BITS)) u_div (
      .clk   (clk),
      .en    (adv),
      .rem_i ({1'b0, a_r[j][33:4]}),
      .low_i ({a_r[j][3:0], 30'd0}),
      .div_i (den73_r),
      .quo_o (quo[j])
    );
  end

  // t, products along the unit vectors, final sum
  always_ff @(posedge clk) begin
    logic [65:0] pa;
    logic [65:0] pb;
    if (adv) begin
      for (int j = 0; j < 2; j++) begin
        tm_r[j] <= sat_r[S_QUO][j] ? lcp_pkg::T_LIMIT : quo[j];
        tn_r[j] <= sgn_r[S_QUO][j];
      end
      for (int i = 0; i < 3; i++) begin
        pa = 66'(tm_r[0]) * 66'(lcp_pkg::mag32(u1d_r[S_T][i]));
        pb = 66'(tm_r[1]) * 66'(lcp_pkg::mag32(u2d_r[S_T][i]));
        tp1_r[i] <= (tn_r[0] ^ u1d_r[S_T][i][31]) ? -$signed(pa[65:30])
                                                   : $signed(pa[65:30]);
        tp2_r[i] <= (tn_r[1] ^ u2d_r[S_T][i][31]) ? -$signed(pb[65:30])
                                                   : $signed(pb[65:30]);
        if (par_r[S_TP]) begin
          on1_r[i] <= p1_r[S_TP][i];
          on2_r[i] <= p2_r[S_TP][i];
        end else begin
          on1_r[i] <= sat32(37'(p1_r[S_TP][i]) + 37'(tp1_r[i]));
          on2_r[i] <= sat32(37'(p2_r[S_TP][i]) + 37'(tp2_r[i]));
        end
      end
      opar_r <= par_r[S_TP];
    end
  end

  // unit vector delay lines
  always_ff @(posedge clk) begin
    if (adv) begin
      u1d_r[S_UNIT+1] <= u1;
      u2d_r[S_UNIT+1] <= u2;
      for (int k = S_UNIT + 2; k <= S_T; k++) begin
        u1d_r[k] <= u1d_r[k-1];
        u2d_r[k] <= u2d_r[k-1];
      end
    end
  end

  assign out_near_first_x   = on1_r[0];
  assign out_near_first_y   = on1_r[1];
  assign out_near_first_z   = on1_r[2];
  assign out_near_second_x  = on2_r[0];
  assign out_near_second_y  = on2_r[1];
  assign out_near_second_z  = on2_r[2];
  assign out_lines_parallel = opar_r;

  // a held pipeline keeps every valid bit in place
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("valid bits moved while the pipeline was held");

  // clamped denominator never reaches the divider as zero
  a_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[S_DEN] |-> (den_r != 31'd0))
    else $error("zero denominator");

  // first normalizer's output never exceeds one in magnitude
  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[S_UNIT] |-> (lcp_pkg::mag32(u1[0]) <= 32'h4000_0000) &&
                    (lcp_pkg::mag32(u1[1]) <= 32'h4000_0000) &&
                    (lcp_pkg::mag32(u1[2]) <= 32'h4000_0000))
    else $error("unit vector component above one");

endmodule

`default_nettype wire

FILE: tb/tb_line_line_closest_points_top.sv
`default_nettype none

module tb_line_line_closest_points_top;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 130;

  typedef lcp_pkg::q16_t q16_t;

  typedef struct {
    q16_t first_point[3];
    q16_t first_dir[3];
    q16_t second_point[3];
    q16_t second_dir[3];
  } line_pair_t;

  typedef struct {
    q16_t near_first[3];
    q16_t near_second[3];
    bit   parallel;
  } near_points_t;

  // Predicts the closest points of each accepted request and checks results in order
  class closest_pair_scoreboard;
    near_points_t expected_points[$];
    logic [31:0]  epsilon = 32'd1;
    int           errors = 0;

    function longint unsigned mg(longint a);
      return a < 0 ? longint'(-a) : a;
    endfunction

    function longint signed_mag(longint unsigned m, bit neg);
      return neg ? -longint'(m) : longint'(m);
    endfunction

    // product of magnitudes shifted right, sign applied: rounds toward zero
    function longint tprod(longint a, longint b, int s);
      longint unsigned p;
      p = (mg(a) * mg(b)) >> s;
      return signed_mag(p, (a < 0) != (b < 0));
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Q2.30 unit vector; zero direction gives zero
    function void unit_vec(input longint d[3], output longint u[3]);
      longint unsigned e[3];
      longint unsigned m, len2, n;
      m = 0;
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
        e[i] = mg(d[i]);
        if (e[i] > m) m = e[i];
      end
      if (m == 0) begin
        u = '{0, 0, 0};
        return;
      end
      while (m < (64'd1 << 30)) begin
        m <<= 1;
        for (int i = 0; i < 3; i++) e[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) len2 += e[i] * e[i];
      n = int_sqrt(len2);
      for (int i = 0; i < 3; i++) u[i] = signed_mag((e[i] << 30) / n, d[i] < 0);
    endfunction

    function longint line_param(longint num, longint den);
      longint unsigned a, q;
      a = mg(num);
      if (a > lcp_pkg::T_LIMIT) q = lcp_pkg::T_LIMIT;
      else begin
        q = (a << 30) / longint'(den);
        if (q > lcp_pkg::T_LIMIT) q = lcp_pkg::T_LIMIT;
      end
      return signed_mag(q, num < 0);
    endfunction

    function q16_t sat_q16(longint x);
      if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (x < -64'sh8000_0000) return 32'sh8000_0000;
      return q16_t'(x);
    endfunction

    function void note_request(line_pair_t r);
      near_points_t res;
      longint p1[3], v1[3], p2[3], v2[3], u1[3], u2[3], c[3];
      longint proj1, proj2, dv, den, t1, t2, diff;
      longint unsigned sq, m;
      bit par;
      for (int i = 0; i < 3; i++) begin
        p1[i] = r.first_point[i];
        v1[i] = r.first_dir[i];
        p2[i] = r.second_point[i];
        v2[i] = r.second_dir[i];
      end
      // parallel test on the raw cross product
      c[0] = tprod(v1[1], v2[2], 16) - tprod(v1[2], v2[1], 16);
      c[1] = tprod(v1[2], v2[0], 16) - tprod(v1[0], v2[2], 16);
      c[2] = tprod(v1[0], v2[1], 16) - tprod(v1[1], v2[0], 16);
      par = 1;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        m = mg(c[i]);
        if (m >= (64'd1 << 24)) par = 0;
        else sq += (m * m) >> 16;
      end
      if (par && sq >= epsilon) par = 0;
      res.parallel = par;
      if (par) begin
        for (int i = 0; i < 3; i++) begin
          res.near_first[i] = r.first_point[i];
          res.near_second[i] = r.second_point[i];
        end
      end else begin
        unit_vec(v1, u1);
        unit_vec(v2, u2);
        proj1 = 0;
        proj2 = 0;
        dv = 0;
        for (int i = 0; i < 3; i++) begin
          diff = p2[i] - p1[i];
          proj1 += tprod(diff, u1[i], 30);
          proj2 += tprod(diff, u2[i], 30);
          dv += tprod(u1[i], u2[i], 30);
        end
        den = (64'sd1 << 30) - tprod(dv, dv, 30);
        if (den < 1) den = 1;
        t1 = line_param(proj1 - tprod(proj2, dv, 30), den);
        t2 = line_param(tprod(proj1, dv, 30) - proj2, den);
        for (int i = 0; i < 3; i++) begin
          res.near_first[i] = sat_q16(p1[i] + tprod(t1, u1[i], 30));
          res.near_second[i] = sat_q16(p2[i] + tprod(t2, u2[i], 30));
        end
      end
      expected_points.push_back(res);
    endfunction

    function void check_result(near_points_t got);
      near_points_t exp_pts;
      string axis[3] = '{"x", "y", "z"};
      if (expected_points.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      exp_pts = expected_points.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got.near_first[i] !== exp_pts.near_first[i]) begin
          $error("near_first_%s: expected %0d, got %0d", axis[i],
                 exp_pts.near_first[i], got.near_first[i]);
          errors++;
        end
        if (got.near_second[i] !== exp_pts.near_second[i]) begin
          $error("near_second_%s: expected %0d, got %0d", axis[i],
                 exp_pts.near_second[i], got.near_second[i]);
          errors++;
        end
      end
      if (got.parallel !== exp_pts.parallel) begin
        $error("lines_parallel: expected %0d, got %0d", exp_pts.parallel, got.parallel);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  q16_t in_fp[3] = '{0, 0, 0};
  q16_t in_fd[3] = '{0, 0, 0};
  q16_t in_sp[3] = '{0, 0, 0};
  q16_t in_sd[3] = '{0, 0, 0};
  logic out_valid;
  logic out_stall = 1'b0;
  q16_t out_nf[3];
  q16_t out_ns[3];
  logic out_lines_parallel;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_parallel_epsilon = '0;

  closest_pair_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int cycles = 0;

  line_line_closest_points_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_first_point_x(in_fp[0]), .in_first_point_y(in_fp[1]), .in_first_point_z(in_fp[2]),
    .in_first_dir_x(in_fd[0]), .in_first_dir_y(in_fd[1]), .in_first_dir_z(in_fd[2]),
    .in_second_point_x(in_sp[0]), .in_second_point_y(in_sp[1]),
    .in_second_point_z(in_sp[2]),
    .in_second_dir_x(in_sd[0]), .in_second_dir_y(in_sd[1]), .in_second_dir_z(in_sd[2]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_near_first_x(out_nf[0]), .out_near_first_y(out_nf[1]),
    .out_near_first_z(out_nf[2]),
    .out_near_second_x(out_ns[0]), .out_near_second_y(out_ns[1]),
    .out_near_second_z(out_ns[2]),
    .out_lines_parallel(out_lines_parallel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_parallel_epsilon(cfg_parallel_epsilon)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** line_line_closest_points_top: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off when hold_req is set
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) hold_left--;
    out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    near_points_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.near_first = out_nf;
      got.near_second = out_ns;
      got.parallel = out_lines_parallel;
      sb.check_result(got);
    end
  end

  task automatic send_request(line_pair_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_fp <= r.first_point;
    in_fd <= r.first_dir;
    in_sp <= r.second_point;
    in_sd <= r.second_dir;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_points.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_epsilon(logic [31:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_parallel_epsilon <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.epsilon = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic q16_t rand_coord(int kind);
    case (kind)
      0: return q16_t'($urandom);
      1: return q16_t'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
      2: return q16_t'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
      default: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 0;
          default: return 32'sh0001_0000;
        endcase
      end
    endcase
  endfunction

  function automatic line_pair_t rand_pair();
    line_pair_t r;
    int pk, dk, shape;
    pk = $urandom_range(0, 9) < 3 ? 0 : $urandom_range(1, 3);
    dk = $urandom_range(0, 3);
    shape = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      r.first_point[i] = rand_coord(pk);
      r.second_point[i] = rand_coord(pk);
      r.first_dir[i] = rand_coord(dk);
      r.second_dir[i] = rand_coord(dk);
    end
    // near-parallel, exactly parallel and zero directions
    if (shape < 3) begin
      for (int i = 0; i < 3; i++)
        r.second_dir[i] = r.first_dir[i] + q16_t'($signed($urandom_range(0, 64)) - 32);
    end else if (shape == 3) begin
      r.second_dir = r.first_dir;
      if ($urandom_range(1)) for (int i = 0; i < 3; i++) r.second_dir[i] = -r.first_dir[i];
    end else if (shape == 4) begin
      r.first_dir = '{0, 0, 0};
    end
    return r;
  endfunction

  function automatic line_pair_t make_pair(q16_t a[3], q16_t da[3], q16_t b[3], q16_t db[3]);
    line_pair_t r;
    r.first_point = a;
    r.first_dir = da;
    r.second_point = b;
    r.second_dir = db;
    return r;
  endfunction

  localparam q16_t ONE = 32'sh0001_0000;
  localparam q16_t MAXV = 32'sh7FFF_FFFF;
  localparam q16_t MINV = 32'sh8000_0000;

  task automatic directed_pairs();
    // skew axes, crossing axes, parallel, anti-parallel
    send_request(make_pair('{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, ONE}, '{0, 0, ONE}));
    send_request(make_pair('{ONE, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}, '{0, ONE, 0}));
    send_request(make_pair('{0, 0, 0}, '{ONE, ONE, 0}, '{ONE, 0, 0}, '{ONE, ONE, 0}));
    send_request(make_pair('{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}, '{-ONE, 0, 0}));
    // zero directions
    send_request(make_pair('{5, 6, 7}, '{0, 0, 0}, '{8, 9, 10}, '{ONE, 0, 0}));
    send_request(make_pair('{5, 6, 7}, '{0, 0, 0}, '{8, 9, 10}, '{0, 0, 0}));
    // extremes of every field
    send_request(make_pair('{MAXV, MAXV, MAXV}, '{MAXV, 0, 0}, '{MINV, MINV, MINV},
                           '{0, MAXV, 0}));
    send_request(make_pair('{MINV, MAXV, MINV}, '{MINV, MINV, MAXV}, '{MAXV, MINV, MAXV},
                           '{MAXV, MINV, MINV}));
    send_request(make_pair('{MINV, MINV, MINV}, '{MINV, MINV, MINV}, '{MAXV, MAXV, MAXV},
                           '{MAXV, MAXV, MAXV}));
    send_request(make_pair('{-1, -1, -1}, '{1, 0, 0}, '{1, 1, 1}, '{0, 1, 0}));
    send_request(make_pair('{MINV, 0, MAXV}, '{MAXV, MAXV, 0}, '{MAXV, 0, MINV},
                           '{MINV, MAXV, 1}));
    // nearly parallel: degenerate denominator and huge line parameters
    send_request(make_pair('{0, 0, 0}, '{MAXV, MAXV, MAXV}, '{MAXV, MINV, 0},
                           '{MAXV, MAXV, MAXV - 1}));
    send_request(make_pair('{MINV, 0, 0}, '{ONE, 0, 0}, '{MAXV, ONE, 0}, '{ONE, 1, 0}));
    send_request(make_pair('{0, MAXV, 0}, '{0, ONE, 1}, '{0, MINV, MAXV}, '{0, ONE, 0}));
  endtask

  initial begin
    logic [31:0] eps_set[8];
    eps_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000, $urandom, 32'h100, 32'd0,
                32'hFFFF_FFFF};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset epsilon, then the two extremes
    directed_pairs();
    write_epsilon(32'd0);
    directed_pairs();
    write_epsilon(32'hFFFF_FFFF);
    directed_pairs();

    for (int ph = 0; ph < 8; ph++) begin
      write_epsilon(eps_set[ph]);
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 77 : 37) : 0;
      stall_pct = (ph % 4 == 2) ? 77 : (ph % 4 == 3 ? 37 : 0);
      if (ph == 4) hold_req = 1;
      repeat (195) send_request(rand_pair());
    end
    send_idle_pct = 0;
    stall_pct = 0;

    wait_drained();
    if (sb.errors == 0) begin
      $display("** line_line_closest_points_top: PASSED **");
    end else begin
      $display("** line_line_closest_points_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/lcp_pkg.sv
rtl/lcp_div.sv
rtl/lcp_unit.sv
rtl/line_line_closest_points_top.sv
tb/tb_line_line_closest_points_top.sv
